@@ rtl/sgu_pkg.sv @@
// ----------------------------------------------------------------------------
// sgu_pkg
// Shared types and constants for the SysEx globals unpacker: section bounds,
// register indexes and the job word handed from the front end to the back end.
// ----------------------------------------------------------------------------
package sgu_pkg;

   // register indexes on the csr port
   localparam logic CSR_HEADER_WORD     = 1'b0;
   localparam logic CSR_EXPECTED_LENGTH = 1'b1;

   // register reset values
   localparam logic [31:0] HEADER_WORD_RESET     = 32'h7E00_2000;
   localparam logic [8:0]  EXPECTED_LENGTH_RESET = 9'd345;

   // message positions
   localparam logic [8:0] POS_MAX        = 9'd511;
   localparam logic [8:0] POS_FIRST_PKT  = 9'd8;
   localparam logic [8:0] POS_MIN_VERDICT = 9'd5;

   // section ranges of raw positions
   localparam logic [8:0] SEC0_FIRST = 9'd8;
   localparam logic [8:0] SEC0_LAST  = 9'd35;
   localparam logic [8:0] SEC1_FIRST = 9'd36;
   localparam logic [8:0] SEC1_LAST  = 9'd181;
   localparam logic [8:0] SEC2_FIRST = 9'd182;
   localparam logic [8:0] SEC2_LAST  = 9'd328;
   localparam logic [8:0] SEC3_FIRST = 9'd329;
   localparam logic [8:0] SEC3_LAST  = 9'd331;
   localparam logic [8:0] SEC4_FIRST = 9'd332;
   localparam logic [8:0] SEC4_LAST  = 9'd338;

   // section codes
   localparam logic [2:0] SEC_KEY_SENS = 3'd0;
   localparam logic [2:0] SEC_TABLE1   = 3'd1;
   localparam logic [2:0] SEC_TABLE2   = 3'd2;
   localparam logic [2:0] SEC_TRIMS    = 3'd3;
   localparam logic [2:0] SEC_OFFSETS  = 3'd4;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one unit of work: a decoded packet with its emit mask, and/or a verdict
   typedef struct packed {
      logic [6:0][7:0] data;
      logic [6:0]      mask;
      logic [5:0]      packet;
      logic            verdict;
      logic            ok;
   } job_type;

endpackage

@@ rtl/sgu_if.sv @@
// ----------------------------------------------------------------------------
// sgu_if
// Valid/ready channels of the unpacker: raw message bytes in, results out.
// ----------------------------------------------------------------------------
interface sgu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

interface sgu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] decoded_byte;
   logic [2:0] section;
   logic [7:0] section_offset;
   logic       is_verdict;
   logic       message_ok;
   logic       last;

   modport source (output valid, decoded_byte, section, section_offset, is_verdict,
                   message_ok, last, input ready);
   modport sink   (input valid, decoded_byte, section, section_offset, is_verdict,
                   message_ok, last, output ready);
endinterface

@@ rtl/sgu_front.sv @@
// ----------------------------------------------------------------------------
// sgu_front
// Accepts message bytes, tracks position and header match, gathers 7-in-8
// packets and pushes a job for every completed packet or message end.
// ----------------------------------------------------------------------------
module sgu_front #(
   parameter int PACKET_COUNT = 42
) (
   input  logic              clock,
   input  logic              reset,
   sgu_req_if.sink           req_chan,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [31:0]       csr_write_data,
   input  logic              queue_full,
   output logic              push,
   output sgu_pkg::job_type  push_job
);

   logic [31:0]     header_word_ff;
   logic [8:0]      expected_length_ff;
   logic [8:0]      pos_ff, pos_in;
   logic            hdr_match_ff, hdr_match_in;
   logic [6:0][7:0] store_ff;
   logic            accept;
   logic [7:0]      want_byte;
   logic            hdr_check;
   logic [5:0]      pkt;
   logic            packet_done;
   logic [6:0]      mask;
   logic [6:0][7:0] decoded;
   logic            ok;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pkt            = pos_ff[8:3];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         header_word_ff     <= sgu_pkg::HEADER_WORD_RESET;
         expected_length_ff <= sgu_pkg::EXPECTED_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sgu_pkg::CSR_HEADER_WORD:     header_word_ff     <= csr_write_data;
            sgu_pkg::CSR_EXPECTED_LENGTH: expected_length_ff <= csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   // header byte expected at this position
   always_comb begin
      want_byte = 8'h00;
      hdr_check = 1'b0;
      case (pos_ff)
         9'd1: begin
            want_byte = header_word_ff[31:24];
            hdr_check = 1'b1;
         end
         9'd2: begin
            want_byte = header_word_ff[23:16];
            hdr_check = 1'b1;
         end
         9'd3: begin
            want_byte = header_word_ff[15:8];
            hdr_check = 1'b1;
         end
         9'd4: begin
            want_byte = header_word_ff[7:0];
            hdr_check = 1'b1;
         end
         default: ;
      endcase
   end

   assign hdr_match_in = hdr_match_ff && !(hdr_check && (want_byte != req_chan.data_byte));
   assign pos_in       = (pos_ff == sgu_pkg::POS_MAX) ? pos_ff : pos_ff + 9'd1;

   // packet completes on its eighth byte
   assign packet_done = (pos_ff >= sgu_pkg::POS_FIRST_PKT) && (pos_ff < sgu_pkg::POS_MAX)
                        && (pkt <= 6'(PACKET_COUNT)) && (pos_ff[2:0] == 3'd7);

   // merge top bits, mark slots that land in a section
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         decoded[i] = store_ff[i] | {req_chan.data_byte[i], 7'b0};
         mask[i]    = packet_done && ({pkt, 3'(i)} <= sgu_pkg::SEC4_LAST);
      end
   end

   assign ok = hdr_match_in && (pos_in >= sgu_pkg::POS_MIN_VERDICT)
               && (pos_in == expected_length_ff);

   assign push            = accept && ((mask != 7'd0) || req_chan.end_of_message);
   assign push_job.data    = decoded;
   assign push_job.mask    = mask;
   assign push_job.packet  = pkt;
   assign push_job.verdict = req_chan.end_of_message;
   assign push_job.ok      = ok;

   // message state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 9'd0;
         hdr_match_ff <= 1'b1;
      end else if (accept) begin
         if (req_chan.end_of_message) begin
            pos_ff       <= 9'd0;
            hdr_match_ff <= 1'b1;
         end else begin
            pos_ff       <= pos_in;
            hdr_match_ff <= hdr_match_in;
         end
      end
   end

   // packet store, one raw byte per slot
   always_ff @(posedge clock) begin
      if (accept && (pos_ff >= sgu_pkg::POS_FIRST_PKT) && (pos_ff[2:0] != 3'd7)) begin
         store_ff[pos_ff[2:0]] <= req_chan.data_byte;
      end
   end

endmodule

@@ rtl/sgu_queue.sv @@
// ----------------------------------------------------------------------------
// sgu_queue
// Short job queue that lets the front end and the back end stall apart.
// ----------------------------------------------------------------------------
module sgu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sgu_pkg::job_type  push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output sgu_pkg::job_type  head_job
);

   localparam int CNT_W = $clog2(sgu_pkg::QUEUE_DEPTH + 1);

   sgu_pkg::job_type             entry_ff [sgu_pkg::QUEUE_DEPTH];
   logic [sgu_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]             count_ff;

   assign full       = (count_ff == CNT_W'(sgu_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

@@ rtl/sgu_back.sv @@
// ----------------------------------------------------------------------------
// sgu_back
// Walks the head job one result per cycle unless stalled: decoded bytes
// in section order, then the verdict, into a registered output word.
// ----------------------------------------------------------------------------
module sgu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  sgu_pkg::job_type  head_job,
   output logic              pop,
   sgu_rsp_if.source         rsp_chan
);

   logic       started_ff, started_in;
   logic [7:0] remain_ff, remain_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [2:0] rsp_sec_ff, rsp_sec_in;
   logic [7:0] rsp_off_ff, rsp_off_in;
   logic       rsp_verdict_ff, rsp_verdict_in;
   logic       rsp_ok_ff, rsp_ok_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       take;
   logic [7:0] bits;
   logic [7:0] pick;
   logic [2:0] slot;
   logic [8:0] pos;
   logic [8:0] off_wide;

   assign take = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign bits = started_ff ? remain_ff : {head_job.verdict, head_job.mask};
   assign pick = bits & (~bits + 8'd1);

   // slot index and data of the picked result
   always_comb begin
      slot        = 3'd0;
      rsp_byte_in = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (pick[i]) slot = 3'(i);
      end
      for (int i = 0; i < 7; i++) begin
         if (pick[i]) rsp_byte_in = head_job.data[i];
      end
   end

   assign pos            = {head_job.packet, slot};
   assign remain_in      = bits & ~pick;
   assign rsp_verdict_in = pick[7];
   assign rsp_ok_in      = pick[7] && head_job.ok;
   assign rsp_last_in    = (remain_in == 8'd0);
   assign pop            = take && rsp_last_in;
   assign started_in     = !rsp_last_in;

   // section lookup
   always_comb begin
      if (pos <= sgu_pkg::SEC0_LAST) begin
         rsp_sec_in = sgu_pkg::SEC_KEY_SENS;
         off_wide   = pos - sgu_pkg::SEC0_FIRST;
      end else if (pos <= sgu_pkg::SEC1_LAST) begin
         rsp_sec_in = sgu_pkg::SEC_TABLE1;
         off_wide   = pos - sgu_pkg::SEC1_FIRST;
      end else if (pos <= sgu_pkg::SEC2_LAST) begin
         rsp_sec_in = sgu_pkg::SEC_TABLE2;
         off_wide   = pos - sgu_pkg::SEC2_FIRST;
      end else if (pos <= sgu_pkg::SEC3_LAST) begin
         rsp_sec_in = sgu_pkg::SEC_TRIMS;
         off_wide   = pos - sgu_pkg::SEC3_FIRST;
      end else begin
         rsp_sec_in = sgu_pkg::SEC_OFFSETS;
         off_wide   = pos - sgu_pkg::SEC4_FIRST;
      end
      rsp_off_in = off_wide[7:0];
      if (pick[7]) begin
         rsp_sec_in = sgu_pkg::SEC_KEY_SENS;
         rsp_off_in = 8'd0;
      end
   end

   // job walk control
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         remain_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            started_ff <= started_in;
            remain_ff  <= remain_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_byte_ff    <= rsp_byte_in;
         rsp_sec_ff     <= rsp_sec_in;
         rsp_off_ff     <= rsp_off_in;
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_ok_ff      <= rsp_ok_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.decoded_byte   = rsp_byte_ff;
   assign rsp_chan.section        = rsp_sec_ff;
   assign rsp_chan.section_offset = rsp_off_ff;
   assign rsp_chan.is_verdict     = rsp_verdict_ff;
   assign rsp_chan.message_ok     = rsp_ok_ff;
   assign rsp_chan.last           = rsp_last_ff;

   // a verdict always closes its job
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_verdict_ff |-> rsp_last_ff)
      else $error("verdict word without last");

   // data words carry no ok flag and a legal section
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_verdict_ff |-> !rsp_ok_ff && (rsp_sec_ff <= sgu_pkg::SEC_OFFSETS))
      else $error("bad data word");

   // a job in progress never has an empty remainder
   assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (remain_ff != 8'd0) && head_valid)
      else $error("job walk lost its head");

endmodule

@@ rtl/sysex_globals_unpacker.sv @@
// ----------------------------------------------------------------------------
// sysex_globals_unpacker
// Streaming 7-in-8 unpacker for a SysEx globals message with header and
// length check.
//
//   channel   dir   handshake           word
//   req_chan  in    valid/ready         data_byte, end_of_message
//   rsp_chan  out   valid/ready         decoded_byte, section, section_offset,
//                                       is_verdict, message_ok, last
//   csr_*     in    write enable only   csr_index, csr_write_data
//
// One byte is accepted per cycle while the four-entry job queue has room.
// A byte that completes a packet or ends the message yields one job; the
// back end drains a job at one result per cycle unless the output stalls
// (up to seven bytes plus a verdict), through the registered output word.
// Synchronous active-high reset clears position, header match, queue and
// output valid; no clearing pass. Output stalls back up through the queue.
// ----------------------------------------------------------------------------
module sysex_globals_unpacker #(
   parameter int PACKET_COUNT = 42
) (
   input  logic        clock,
   input  logic        reset,
   sgu_req_if.sink     req_chan,
   sgu_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   logic             queue_full;
   logic             push;
   sgu_pkg::job_type push_job;
   logic             pop;
   logic             head_valid;
   sgu_pkg::job_type head_job;

   // byte intake and packet gathering
   sgu_front #(
      .PACKET_COUNT (PACKET_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   // job queue
   sgu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // result emission
   sgu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
